[sv/stec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stec_pkg
// Shared types and constants for the speech turn endpoint controller.
// ----------------------------------------------------------------------------
package stec_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int SIL_W         = 16;
    localparam int FRAME_W       = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [SIL_W-1:0]   SILENCE_END_RST = 16'd1000;
    localparam logic [SIL_W-1:0]   FOLLOWUP_WIN_RST = 16'd8000;
    localparam logic [SIL_W-1:0]   WARMUP_RST       = 16'd200;
    localparam logic [FRAME_W-1:0] FRAME_MS_RST     = 8'd30;

    localparam logic [SIL_W-1:0] SIL_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_END  = 2'd0,
        CFG_FOLLOWUP_WIN = 2'd1,
        CFG_WARMUP       = 2'd2,
        CFG_FRAME_MS     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LISTEN = 2'd1,
        MODE_PLAY   = 2'd2
    } mode_t;

    localparam logic [1:0] TARGET_INVALID = 2'd3;

    typedef enum logic [2:0] {
        ACT_FRAME    = 3'd0,
        ACT_WAKE     = 3'd1,
        ACT_SET_MODE = 3'd2,
        ACT_FOLLOWUP = 3'd3,
        ACT_TICK     = 3'd4
    } action_t;

    typedef struct packed {
        logic [SIL_W-1:0]   silence_end_ms;
        logic [SIL_W-1:0]   followup_win;
        logic [SIL_W-1:0]   warmup_ms;
        logic [FRAME_W-1:0] frame_ms;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        logic  end_of_speech;
        logic  followup_expired;
        logic  speech_heard;
        logic  frame_ignored;
    } result_t;

endpackage

[sv/speech_turn_endpoint_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speech_turn_endpoint_controller
// Voice-turn mode controller: idle, listening, playback, driven by frame,
// wake, mode, follow-up and tick events.
// ----------------------------------------------------------------------------
// Takes one event per clock while the output channel is not stalled and
// returns one result per event. An event is captured in the input register,
// the turn state is updated from it by a single level of compare/add logic,
// and the result lands in the output register, which drives the m_ ports.
// Each event sees the state left by the previous one. While a result waits
// in the output register one more event can be taken into the input
// register; after that s_ready stays low until m_ready returns. Registers
// must be written through the cfg_* port only while no event is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module speech_turn_endpoint_controller #(
    parameter int TIME_BITS = stec_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [stec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_action,
    input  logic                             s_vad_speech,
    input  logic [1:0]                       s_target_mode,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_mode,
    output logic                             m_end_of_speech,
    output logic                             m_followup_expired,
    output logic                             m_speech_heard,
    output logic                             m_frame_ignored
);

    stec_pkg::cfg_t    cfg;
    stec_pkg::result_t res;
    stec_pkg::result_t m_res;
    logic              res_valid;
    logic              res_ready;

    stec_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    stec_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_vad_speech  (s_vad_speech),
        .s_target_mode (s_target_mode),
        .cfg           (cfg),
        .res_ready     (res_ready),
        .res_valid     (res_valid),
        .res           (res)
    );

    stec_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_mode             = m_res.mode;
    assign m_end_of_speech    = m_res.end_of_speech;
    assign m_followup_expired = m_res.followup_expired;
    assign m_speech_heard     = m_res.speech_heard;
    assign m_frame_ignored    = m_res.frame_ignored;

endmodule

[sv/stec_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stec_cfg_regs
// Configuration register file, write only, one register per index.
// ----------------------------------------------------------------------------
module stec_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [stec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output stec_pkg::cfg_t                   cfg
);

    stec_pkg::cfg_t cfg_reg;
    stec_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (stec_pkg::cfg_idx_t'(cfg_index))
                stec_pkg::CFG_SILENCE_END:  cfg_next.silence_end_ms = cfg_wdata;
                stec_pkg::CFG_FOLLOWUP_WIN: cfg_next.followup_win   = cfg_wdata;
                stec_pkg::CFG_WARMUP:       cfg_next.warmup_ms      = cfg_wdata;
                stec_pkg::CFG_FRAME_MS:
                    cfg_next.frame_ms = cfg_wdata[stec_pkg::FRAME_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence_end_ms <= stec_pkg::SILENCE_END_RST;
            cfg_reg.followup_win   <= stec_pkg::FOLLOWUP_WIN_RST;
            cfg_reg.warmup_ms      <= stec_pkg::WARMUP_RST;
            cfg_reg.frame_ms       <= stec_pkg::FRAME_MS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/stec_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stec_core
// Input register, turn state and the per-item state update.
// ----------------------------------------------------------------------------
module stec_core #(
    parameter int TIME_BITS = stec_pkg::TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_action,
    input  logic                s_vad_speech,
    input  logic [1:0]          s_target_mode,
    input  stec_pkg::cfg_t      cfg,
    input  logic                res_ready,
    output logic                res_valid,
    output stec_pkg::result_t   res
);

    localparam int CMP_W = (TIME_BITS > stec_pkg::SIL_W) ? TIME_BITS : stec_pkg::SIL_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                       in_valid_reg;
    stec_pkg::action_t          action_reg;
    logic                       vad_reg;
    logic [1:0]                 target_reg;

    stec_pkg::mode_t            mode_reg, mode_next;
    logic [stec_pkg::SIL_W-1:0] silence_reg, silence_next;
    logic                       seen_reg, seen_next;
    logic                       fopen_reg, fopen_next;
    logic [TIME_BITS-1:0]       elapsed_reg, elapsed_next;

    logic                       adv;
    logic [CMP_W-1:0]           el_w, warm_w, win_w;
    logic [stec_pkg::SIL_W:0]   sil_sum;
    logic [stec_pkg::SIL_W-1:0] sil_sat;
    logic                       eos, expired, ignored;

    assign adv       = in_valid_reg && res_ready;
    assign s_ready   = !in_valid_reg || res_ready;
    assign res_valid = in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= stec_pkg::action_t'(s_action);
            vad_reg    <= s_vad_speech;
            target_reg <= s_target_mode;
        end
    end

    assign el_w    = CMP_W'(elapsed_reg);
    assign warm_w  = CMP_W'(cfg.warmup_ms);
    assign win_w   = CMP_W'(cfg.followup_win);
    assign sil_sum = {1'b0, silence_reg} + (stec_pkg::SIL_W + 1)'(cfg.frame_ms);
    assign sil_sat = sil_sum[stec_pkg::SIL_W] ? stec_pkg::SIL_MAX
                                               : sil_sum[stec_pkg::SIL_W-1:0];

    always_comb begin
        mode_next    = mode_reg;
        silence_next = silence_reg;
        seen_next    = seen_reg;
        fopen_next   = fopen_reg;
        elapsed_next = elapsed_reg;
        eos          = 1'b0;
        expired      = 1'b0;
        ignored      = 1'b0;
        case (action_reg)
            stec_pkg::ACT_FRAME: begin
                if (mode_reg != stec_pkg::MODE_LISTEN) begin
                    ignored = 1'b1;
                end else if (el_w < warm_w) begin
                    ignored = 1'b1;
                end else if (fopen_reg && !seen_reg && el_w > win_w) begin
                    mode_next  = stec_pkg::MODE_IDLE;
                    fopen_next = 1'b0;
                    expired    = 1'b1;
                end else if (vad_reg) begin
                    seen_next    = 1'b1;
                    silence_next = '0;
                end else if (seen_reg) begin
                    silence_next = sil_sat;
                    if (sil_sat >= cfg.silence_end_ms) begin
                        mode_next    = stec_pkg::MODE_PLAY;
                        fopen_next   = 1'b0;
                        silence_next = '0;
                        eos          = 1'b1;
                    end
                end
            end
            stec_pkg::ACT_WAKE, stec_pkg::ACT_FOLLOWUP: begin
                if (mode_reg != stec_pkg::MODE_LISTEN) begin
                    mode_next    = stec_pkg::MODE_LISTEN;
                    silence_next = '0;
                    seen_next    = 1'b0;
                    elapsed_next = '0;
                end
                if (action_reg == stec_pkg::ACT_FOLLOWUP) begin
                    fopen_next = 1'b1;
                end
            end
            stec_pkg::ACT_SET_MODE: begin
                if (target_reg != stec_pkg::TARGET_INVALID &&
                    stec_pkg::mode_t'(target_reg) != mode_reg) begin
                    mode_next = stec_pkg::mode_t'(target_reg);
                    if (stec_pkg::mode_t'(target_reg) == stec_pkg::MODE_LISTEN) begin
                        silence_next = '0;
                        seen_next    = 1'b0;
                        elapsed_next = '0;
                    end else begin
                        fopen_next = 1'b0;
                    end
                end
            end
            stec_pkg::ACT_TICK: begin
                if (elapsed_reg != TIME_MAX) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= stec_pkg::MODE_IDLE;
            silence_reg <= '0;
            seen_reg    <= 1'b0;
            fopen_reg   <= 1'b0;
            elapsed_reg <= '0;
        end else if (adv) begin
            mode_reg    <= mode_next;
            silence_reg <= silence_next;
            seen_reg    <= seen_next;
            fopen_reg   <= fopen_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign res.mode             = mode_next;
    assign res.end_of_speech    = eos;
    assign res.followup_expired = expired;
    assign res.speech_heard     = seen_next;
    assign res.frame_ignored    = ignored;

    a_fopen_listen: assert property (@(posedge aclk) disable iff (!aresetn)
        fopen_reg |-> mode_reg == stec_pkg::MODE_LISTEN)
        else $error("follow-up window open outside listening");

    a_eos_play: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.end_of_speech |-> res.mode == stec_pkg::MODE_PLAY)
        else $error("end of speech without playback");

    a_exp_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.followup_expired |-> res.mode == stec_pkg::MODE_IDLE)
        else $error("follow-up expiry without idle");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> $countones({res.end_of_speech, res.followup_expired,
                                   res.frame_ignored}) <= 1)
        else $error("conflicting result flags");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(mode_reg) && $stable(elapsed_reg) && $stable(silence_reg))
        else $error("state changed without a transfer");

endmodule

[sv/stec_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stec_out_stage
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module stec_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    input  stec_pkg::result_t  res,
    output logic               res_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output stec_pkg::result_t  m_res
);

    logic              valid_reg;
    stec_pkg::result_t res_reg;

    assign res_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

[bench/tb_speech_turn_endpoint_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_speech_turn_endpoint_controller
// Self-checking bench for the speech turn endpoint controller.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the turn state and registers,
// predicts one result per accepted event and checks every result transfer
// against the oldest prediction. Stimulus starts with a short directed run,
// then drives the silence count to its clamp, then runs random turns (wake,
// follow-up or listen mode set, warmup ticks, speech and silence frames,
// noise) under several register settings. Both channels idle and stall in
// random bursts except in the final phase.
// ----------------------------------------------------------------------------
module tb_speech_turn_endpoint_controller;
    import stec_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam logic [2:0]  ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI = 3'd7;

    class turn_scoreboard;
        logic [SIL_W-1:0]         silence_end;
        logic [SIL_W-1:0]         followup_win;
        logic [SIL_W-1:0]         warmup;
        logic [FRAME_W-1:0]       frame_len;
        mode_t                    mode;
        logic [SIL_W-1:0]         silence;
        logic                     heard;
        logic                     followup_open;
        logic [TIME_BITS_DEF-1:0] elapsed;
        result_t                  pending_results[$];
        int unsigned              errors;

        function new();
            silence_end   = SILENCE_END_RST;
            followup_win  = FOLLOWUP_WIN_RST;
            warmup        = WARMUP_RST;
            frame_len     = FRAME_MS_RST;
            mode          = MODE_IDLE;
            silence       = '0;
            heard         = 1'b0;
            followup_open = 1'b0;
            elapsed       = '0;
            errors        = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SILENCE_END:  silence_end  = value;
                CFG_FOLLOWUP_WIN: followup_win = value;
                CFG_WARMUP:       warmup       = value;
                CFG_FRAME_MS:     frame_len    = value[FRAME_W-1:0];
                default: ;
            endcase
        endfunction

        function void switch_mode(mode_t m);
            if (mode != m) begin
                mode = m;
                if (m == MODE_LISTEN) begin
                    silence = '0;
                    heard   = 1'b0;
                    elapsed = '0;
                end else begin
                    followup_open = 1'b0;
                end
            end
        endfunction

        function void note_event(logic [2:0] act, logic vad, logic [1:0] tgt);
            result_t          r;
            logic [SIL_W:0]   sum;
            r = '0;
            case (act)
                ACT_FRAME: begin
                    if (mode != MODE_LISTEN) begin
                        r.frame_ignored = 1'b1;
                    end else if (elapsed < warmup) begin
                        r.frame_ignored = 1'b1;
                    end else if (followup_open && !heard && elapsed > followup_win) begin
                        switch_mode(MODE_IDLE);
                        r.followup_expired = 1'b1;
                    end else if (vad) begin
                        heard   = 1'b1;
                        silence = '0;
                    end else if (heard) begin
                        sum = {1'b0, silence} + {{(SIL_W+1-FRAME_W){1'b0}}, frame_len};
                        silence = sum[SIL_W] ? SIL_MAX : sum[SIL_W-1:0];
                        if (silence >= silence_end) begin
                            switch_mode(MODE_PLAY);
                            silence         = '0;
                            r.end_of_speech = 1'b1;
                        end
                    end
                end
                ACT_WAKE: switch_mode(MODE_LISTEN);
                ACT_SET_MODE: begin
                    if (tgt != TARGET_INVALID)
                        switch_mode(mode_t'(tgt));
                end
                ACT_FOLLOWUP: begin
                    switch_mode(MODE_LISTEN);
                    followup_open = 1'b1;
                end
                ACT_TICK: begin
                    if (elapsed != '1)
                        elapsed = elapsed + 1'b1;
                end
                default: ;
            endcase
            r.mode         = mode;
            r.speech_heard = heard;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("extra result: mode=%0d eos=%0b exp=%0b heard=%0b ign=%0b",
                             got.mode, got.end_of_speech, got.followup_expired,
                             got.speech_heard, got.frame_ignored);
            end else begin
                want = pending_results.pop_front();
                if (got.mode !== want.mode || got.end_of_speech !== want.end_of_speech ||
                    got.followup_expired !== want.followup_expired ||
                    got.speech_heard !== want.speech_heard ||
                    got.frame_ignored !== want.frame_ignored) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at %0t: expected mode=%0d eos=%0b exp=%0b %s",
                                 $realtime, want.mode, want.end_of_speech,
                                 want.followup_expired, "");
                        $display("    expected heard=%0b ign=%0b",
                                 want.speech_heard, want.frame_ignored);
                        $display("    got mode=%0d eos=%0b exp=%0b heard=%0b ign=%0b",
                                 got.mode, got.end_of_speech, got.followup_expired,
                                 got.speech_heard, got.frame_ignored);
                    end
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [2:0]            s_action = '0;
    logic                  s_vad_speech = 1'b0;
    logic [1:0]            s_target_mode = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [1:0]            m_mode;
    logic                  m_end_of_speech;
    logic                  m_followup_expired;
    logic                  m_speech_heard;
    logic                  m_frame_ignored;

    turn_scoreboard board = new();
    bit             gaps_on = 1'b1;
    bit             stalls_on = 1'b1;
    int unsigned    stall_left = 0;
    int unsigned    events_sent = 0;

    speech_turn_endpoint_controller dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_vad_speech       (s_vad_speech),
        .s_target_mode      (s_target_mode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_mode             (m_mode),
        .m_end_of_speech    (m_end_of_speech),
        .m_followup_expired (m_followup_expired),
        .m_speech_heard     (m_speech_heard),
        .m_frame_ignored    (m_frame_ignored)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.mode             = mode_t'(m_mode);
            got.end_of_speech    = m_end_of_speech;
            got.followup_expired = m_followup_expired;
            got.speech_heard     = m_speech_heard;
            got.frame_ignored    = m_frame_ignored;
            board.check_result(got);
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    // Called right after a falling edge; returns just after the falling edge that comes once
    // the event is taken, with valid still high, so back-to-back events keep valid asserted.
    task automatic send_event(input logic [2:0] act, input logic vad, input logic [1:0] tgt);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_action      = act;
        s_vad_speech  = vad;
        s_target_mode = tgt;
        do @(posedge aclk); while (!s_ready);
        board.note_event(act, vad, tgt);
        events_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic vad);
        send_event(ACT_FRAME, vad, 2'($urandom_range(0, 3)));
    endtask

    task automatic send_tick();
        send_event(ACT_TICK, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (board.pending_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic program_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        board.write_reg(idx, value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic configure(input logic [SIL_W-1:0] sil_end, input logic [SIL_W-1:0] fu_win,
                             input logic [SIL_W-1:0] warm, input logic [FRAME_W-1:0] frame);
        settle();
        program_reg(CFG_SILENCE_END, sil_end);
        program_reg(CFG_FOLLOWUP_WIN, fu_win);
        program_reg(CFG_WARMUP, warm);
        // upper data bits are don't-care for the 8-bit register
        program_reg(CFG_FRAME_MS, {8'($urandom), frame});
    endtask

    task automatic random_turn(input int unsigned warm);
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 9);
        if (r < 5)
            send_event(ACT_WAKE, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        else if (r < 8)
            send_event(ACT_FOLLOWUP, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
        else
            send_event(ACT_SET_MODE, 1'($urandom_range(0, 1)), MODE_LISTEN);
        n = $urandom_range(0, warm + 2);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0)
                send_frame(1'($urandom_range(0, 1)));
            send_tick();
        end
        n = $urandom_range(6, 30);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_frame($urandom_range(0, 2) == 0);
            else if (r < 75)
                send_tick();
            else if (r < 80)
                send_event(ACT_WAKE, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            else if (r < 86)
                send_event(ACT_SET_MODE, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            else if (r < 89)
                send_event(ACT_FOLLOWUP, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            else
                send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)));
        end
    endtask

    task automatic random_phase(input int unsigned quota);
        int unsigned start;
        start = events_sent;
        while (events_sent - start < quota)
            random_turn(board.warmup);
    endtask

    initial begin : main
        int unsigned p;
        logic [2:0]  a;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset settings: idle frame, tick, invalid target, unused actions, warmup
        send_frame(1'b0);
        send_tick();
        send_event(ACT_SET_MODE, 1'b1, TARGET_INVALID);
        for (a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI && a >= ACT_UNUSED_LO; a++)
            send_event(a, 1'b1, TARGET_INVALID);
        send_event(ACT_WAKE, 1'b0, MODE_IDLE);
        send_frame(1'b1);
        send_event(ACT_SET_MODE, 1'b0, MODE_PLAY);

        // small settings: speech, silence to end of turn, follow-up expiry
        configure(16'd60, 16'd3, 16'd2, 8'd30);
        send_event(ACT_WAKE, 1'b1, TARGET_INVALID);
        send_tick();
        send_tick();
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b0);
        send_frame(1'b1);
        send_event(ACT_SET_MODE, 1'b1, MODE_PLAY);
        send_event(ACT_FOLLOWUP, 1'b0, MODE_PLAY);
        repeat (4) send_tick();
        send_frame(1'b0);
        send_event(ACT_SET_MODE, 1'b0, MODE_IDLE);
        send_event(ACT_FOLLOWUP, 1'b1, MODE_IDLE);
        send_event(ACT_SET_MODE, 1'b0, MODE_LISTEN);
        send_frame(1'b0);

        // silence count clamps at full scale and still ends the turn
        configure(16'hFFFF, 16'hFFFF, 16'd0, 8'd254);
        send_event(ACT_WAKE, 1'b0, MODE_IDLE);
        send_frame(1'b1);
        repeat (260) send_frame(1'b0);

        for (p = 0; p < 12; p++) begin
            if (p == 11) begin
                settle();
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if (p == 0)
                configure(16'd0, 16'd0, 16'd0, 8'd1);
            else if (p == 1)
                configure(16'hFFFF, 16'hFFFF, 16'd0, 8'd255);
            else
                configure(16'($urandom_range(0, 150)), 16'($urandom_range(0, 25)),
                          16'($urandom_range(0, 10)), 8'($urandom_range(1, 50)));
            random_phase(60);
        end

        s_valid = 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
